### sv/rhhm_pkg.sv
`timescale 1ns / 1ps
package rhhm_pkg;
   localparam int CAPACITY = 256;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int DIST_W = IDX_W + 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int KEY_W = 64;
   localparam int VAL_W = 64;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [DIST_W-1:0] distance;
   } entry_type;

   typedef struct packed {
      logic we;
      logic [IDX_W-1:0] addr;
      entry_type wdata;
   } mem_req_type;

   // first half of the key mix, up to the multiply by 21
   function automatic logic [63:0] mix_front(input logic [63:0] k);
      logic [63:0] h;
      h = (~k) + (k << 18);
      h = h ^ (h >> 31);
      return (h << 4) + (h << 2) + h;
   endfunction

   // second half of the key mix, reduced to a slot index
   function automatic logic [IDX_W-1:0] mix_back(input logic [63:0] m);
      logic [63:0] h;
      h = m ^ (m >> 11);
      h = h + (h << 6);
      h = h ^ (h >> 22);
      return IDX_W'(h[29:0] % CAPACITY);
   endfunction
endpackage

### sv/robin_hood_hash_map.sv
`timescale 1ns / 1ps
// Channel | Ports                                   | Transfer
// request | start, busy, req_cmd/key/data_in        | start && !busy
// result  | rsp_valid, rsp_hit/data_out/status      | rsp_valid, one cycle
// The key hash is split over the accepting edge (mix_front) and S_HASH
// (mix_back); each slot probed then costs one memory read. A lookup or
// update raises its registered strobe from the probe that finds the key
// or the miss; a refused insert from its miss probe. A new key probes to
// the miss, walks again from home through S_PLACE and S_ADVANCE for each
// occupied slot passed (read, then write-back or re-read) and writes the empty slot it lands in.
// busy falls as the strobe rises; the receiver cannot stall.
// Reset clears all slot valid flags together; no clearing pass.
module robin_hood_hash_map (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_cmd,
   input  logic [63:0] req_key,
   input  logic [63:0] req_data_in,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic [63:0] rsp_data_out,
   output logic [1:0] rsp_status
);
   rhhm_pkg::mem_req_type mreq;
   rhhm_pkg::entry_type rd_entry;
   logic rd_valid;

   rhhm_store u_store (.clock, .reset, .req(mreq), .rd_valid, .rd_entry);

   rhhm_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .req_cmd, .req_key, .req_data_in,
      .mreq, .rd_valid, .rd_entry,
      .rsp_valid, .rsp_hit, .rsp_data_out, .rsp_status
   );
endmodule

### sv/rhhm_store.sv
`timescale 1ns / 1ps
module rhhm_store (
   input  logic clock,
   input  logic reset,
   input  rhhm_pkg::mem_req_type req,
   output logic rd_valid,
   output rhhm_pkg::entry_type rd_entry
);
   rhhm_pkg::entry_type mem [rhhm_pkg::CAPACITY];
   logic [rhhm_pkg::CAPACITY-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rd_entry <= mem[req.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid <= 1'b0;
      end else begin
         if (req.we) begin
            valid_ff[req.addr] <= 1'b1;
         end
         rd_valid <= valid_ff[req.addr];
      end
   end
endmodule

### sv/rhhm_ctrl.sv
`timescale 1ns / 1ps
module rhhm_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_cmd,
   input  logic [63:0] req_key,
   input  logic [63:0] req_data_in,
   output rhhm_pkg::mem_req_type mreq,
   input  logic rd_valid,
   input  rhhm_pkg::entry_type rd_entry,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic [63:0] rsp_data_out,
   output logic [1:0] rsp_status
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HASH = 3'd1;
   localparam logic [2:0] S_FIND = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_ADVANCE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic cmd_ff;
   logic [63:0] key_ff, data_ff, mix_ff;
   logic [rhhm_pkg::IDX_W-1:0] home_ff;
   logic [rhhm_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [rhhm_pkg::DIST_W-1:0] dist_ff, dist_in;
   rhhm_pkg::entry_type carry_ff, carry_in;
   logic [rhhm_pkg::CNT_W-1:0] count_ff, count_in;
   logic out_v_in, out_hit_in;
   logic [63:0] out_d_in;
   logic [1:0] out_st_in;
   logic [rhhm_pkg::CNT_W+1:0] next_count;

   assign busy = (state_ff != S_IDLE);
   assign next_count = (rhhm_pkg::CNT_W+2)'(count_ff) + (rhhm_pkg::CNT_W+2)'(1);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      dist_in = dist_ff;
      carry_in = carry_ff;
      count_in = count_ff;
      out_v_in = 1'b0;
      out_hit_in = 1'b0;
      out_d_in = '0;
      out_st_in = rhhm_pkg::ST_OK;
      mreq.we = 1'b0;
      mreq.addr = idx_ff;
      mreq.wdata = carry_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            idx_in = rhhm_pkg::mix_back(mix_ff);
            dist_in = '0;
            mreq.addr = idx_in;
            state_in = S_FIND;
         end
         S_FIND: begin
            // read data of idx_ff is present; next address issued on mreq
            if (!rd_valid || dist_ff > rd_entry.distance) begin
               if (cmd_ff == rhhm_pkg::CMD_LOOKUP) begin
                  out_v_in = 1'b1;
                  out_st_in = rhhm_pkg::ST_MISS;
                  state_in = S_IDLE;
               end else if ((next_count << 2) > (rhhm_pkg::CNT_W+2)'(3 * rhhm_pkg::CAPACITY))
               begin
                  out_v_in = 1'b1;
                  out_st_in = rhhm_pkg::ST_FULL;
                  state_in = S_IDLE;
               end else begin
                  // restart the walk from home with the new entry carried
                  carry_in.key = key_ff;
                  carry_in.value = data_ff;
                  carry_in.distance = '0;
                  idx_in = home_ff;
                  dist_in = '0;
                  mreq.addr = idx_in;
                  state_in = S_PLACE;
               end
            end else if (rd_entry.key == key_ff) begin
               out_v_in = 1'b1;
               state_in = S_IDLE;
               if (cmd_ff == rhhm_pkg::CMD_LOOKUP) begin
                  out_hit_in = 1'b1;
                  out_d_in = rd_entry.value;
               end else begin
                  mreq.we = 1'b1;
                  mreq.wdata = rd_entry;
                  mreq.wdata.value = data_ff;
               end
            end else begin
               idx_in = idx_ff + (rhhm_pkg::IDX_W)'(1);
               dist_in = dist_ff + (rhhm_pkg::DIST_W)'(1);
               mreq.addr = idx_in;
            end
         end
         S_PLACE: begin
            // write at idx_ff, read of idx_ff+1 issues next cycle
            if (!rd_valid) begin
               mreq.we = 1'b1;
               count_in = count_ff + (rhhm_pkg::CNT_W)'(1);
               out_v_in = 1'b1;
               out_hit_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               if (carry_ff.distance > rd_entry.distance) begin
                  mreq.we = 1'b1;
                  carry_in = rd_entry;
               end
               carry_in.distance = carry_in.distance + (rhhm_pkg::DIST_W)'(1);
               idx_in = idx_ff + (rhhm_pkg::IDX_W)'(1);
               state_in = S_ADVANCE;
            end
         end
         S_ADVANCE: begin
            // re-read next slot after the S_PLACE write-back or re-read
            mreq.addr = idx_ff;
            state_in = S_PLACE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         data_ff <= req_data_in;
         mix_ff <= rhhm_pkg::mix_front(req_key);
      end
      if (state_ff == S_HASH) begin
         home_ff <= idx_in;
      end
      idx_ff <= idx_in;
      dist_ff <= dist_in;
      carry_ff <= carry_in;
      rsp_hit <= out_hit_in;
      rsp_data_out <= out_d_in;
      rsp_status <= out_st_in;
   end
endmodule

### sv/rhhm_checker.sv
`timescale 1ns / 1ps
module rhhm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_hit,
   input logic [63:0] rsp_data_out,
   input logic [1:0] rsp_status
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept without busy");
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rhhm_pkg::ST_OK |-> rsp_data_out == 64'd0)
      else $error("data on failure");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
   a_miss_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rhhm_pkg::ST_OK |-> !rsp_hit)
      else $error("hit on failure");
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
endmodule

bind robin_hood_hash_map rhhm_checker u_chk (.*);

### tb/robin_hood_hash_map_tb.sv
`timescale 1ns / 1ps
module robin_hood_hash_map_tb;
   typedef struct packed {
      logic hit;
      logic [63:0] data_out;
      logic [1:0] status;
   } map_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = rhhm_pkg::CMD_LOOKUP;
   logic [63:0] req_key = '0;
   logic [63:0] req_data_in = '0;
   logic rsp_valid;
   logic rsp_hit;
   logic [63:0] rsp_data_out;
   logic [1:0] rsp_status;

   robin_hood_hash_map dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_key(req_key), .req_data_in(req_data_in),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_data_out(rsp_data_out),
      .rsp_status(rsp_status)
   );

   initial forever #2 clock = ~clock;

   // shadow table
   bit tbl_valid [rhhm_pkg::CAPACITY];
   logic [63:0] tbl_key [rhhm_pkg::CAPACITY];
   logic [63:0] tbl_val [rhhm_pkg::CAPACITY];
   int unsigned tbl_dist [rhhm_pkg::CAPACITY];
   int unsigned tbl_count;

   map_result_type pending_results[$];
   logic [63:0] known_keys[$];
   int unsigned mismatches = 0;
   int unsigned idle_pct = 0;
   longint unsigned cycle_count = 0;

   function automatic int unsigned hash_home(logic [63:0] k);
      logic [63:0] h;
      h = (~k) + (k << 18);
      h = h ^ (h >> 31);
      h = h * 64'd21;
      h = h ^ (h >> 11);
      h = h + (h << 6);
      h = h ^ (h >> 22);
      return 32'((h & 64'h3fff_ffff) % 64'(rhhm_pkg::CAPACITY));
   endfunction

   function automatic bit locate(logic [63:0] k, output int unsigned where);
      int unsigned idx;
      idx = hash_home(k);
      where = 0;
      for (int unsigned d = 0; d < rhhm_pkg::CAPACITY; d++) begin
         if (!tbl_valid[idx] || d > tbl_dist[idx]) return 0;
         if (tbl_key[idx] == k) begin
            where = idx;
            return 1;
         end
         idx = (idx + 1) % rhhm_pkg::CAPACITY;
      end
      return 0;
   endfunction

   function automatic void carry_insert(logic [63:0] k, logic [63:0] v);
      int unsigned idx, cd, td;
      logic [63:0] ck, cv, tk, tv;
      idx = hash_home(k);
      ck = k;
      cv = v;
      cd = 0;
      for (int n = 0; n < rhhm_pkg::CAPACITY; n++) begin
         if (!tbl_valid[idx]) begin
            tbl_valid[idx] = 1'b1;
            tbl_key[idx] = ck;
            tbl_val[idx] = cv;
            tbl_dist[idx] = cd;
            return;
         end
         if (cd > tbl_dist[idx]) begin
            tk = tbl_key[idx]; tv = tbl_val[idx]; td = tbl_dist[idx];
            tbl_key[idx] = ck; tbl_val[idx] = cv; tbl_dist[idx] = cd;
            ck = tk; cv = tv; cd = td;
         end
         idx = (idx + 1) % rhhm_pkg::CAPACITY;
         cd++;
      end
   endfunction

   function automatic map_result_type predict_map(logic cmd, logic [63:0] k,
         logic [63:0] v);
      map_result_type r;
      int unsigned where;
      bit found;
      r = '0;
      found = locate(k, where);
      if (cmd == rhhm_pkg::CMD_LOOKUP) begin
         if (found) begin
            r.hit = 1'b1;
            r.data_out = tbl_val[where];
         end else begin
            r.status = rhhm_pkg::ST_MISS;
         end
      end else if (found) begin
         tbl_val[where] = v;
      end else if (4 * (tbl_count + 1) > 3 * rhhm_pkg::CAPACITY) begin
         r.status = rhhm_pkg::ST_FULL;
      end else begin
         carry_insert(k, v);
         tbl_count++;
         r.hit = 1'b1;
         known_keys.push_back(k);
      end
      return r;
   endfunction

   // start stays high between back-to-back transactions; drop it only to idle
   task automatic send_op(logic cmd, logic [63:0] k, logic [63:0] v);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_cmd <= cmd;
      req_key <= k;
      req_data_in <= v;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_map(cmd, k, v));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd2_000_000) begin
         $display("robin_hood_hash_map_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      map_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycle_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit || rsp_data_out !== want.data_out ||
                  rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hit %0b data %h st %0d, got hit %0b data %h st %0d",
                     want.hit, want.data_out, want.status, rsp_hit, rsp_data_out, rsp_status);
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_key();
      if (known_keys.size() != 0 && $urandom_range(99) < 60)
         return known_keys[$urandom_range(known_keys.size() - 1)];
      return rand64();
   endfunction

   task automatic test_directed();
      send_op(rhhm_pkg::CMD_LOOKUP, 64'h0, 64'h0);
      send_op(rhhm_pkg::CMD_INSERT, 64'h0, '1);
      send_op(rhhm_pkg::CMD_INSERT, '1, 64'h0);
      send_op(rhhm_pkg::CMD_LOOKUP, 64'h0, 64'h0);
      send_op(rhhm_pkg::CMD_LOOKUP, '1, '1);
      send_op(rhhm_pkg::CMD_INSERT, 64'h0, 64'h1234_5678_9abc_def0);
      send_op(rhhm_pkg::CMD_LOOKUP, 64'h0, 64'h0);
      send_op(rhhm_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, 64'h0);
      send_op(rhhm_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_op(rhhm_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 64'h0);
   endtask

   // fill to the load limit, hit the refusal, update while full, then look up
   task automatic test_fill_to_limit();
      while (tbl_count < (3 * rhhm_pkg::CAPACITY) / 4)
         send_op(rhhm_pkg::CMD_INSERT, rand64(), rand64());
      send_op(rhhm_pkg::CMD_INSERT, rand64(), rand64());
      send_op(rhhm_pkg::CMD_INSERT, known_keys[0], rand64());
      send_op(rhhm_pkg::CMD_LOOKUP, known_keys[0], 64'h0);
      for (int i = 0; i < 40; i++) send_op(rhhm_pkg::CMD_LOOKUP, pick_key(), rand64());
   endtask

   task automatic test_random(int n, int unsigned pct);
      idle_pct = pct;
      for (int i = 0; i < n; i++) send_op(1'($urandom_range(1)), pick_key(), rand64());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(150, 0);
      test_random(150, 63);
      test_random(150, 27);
      test_fill_to_limit();
      test_random(100, 0);
      test_random(100, 63);
      start <= 1'b0;
      idle_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (rhhm_pkg::CAPACITY * 4) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("robin_hood_hash_map_tb: PASS");
      else
         $display("robin_hood_hash_map_tb: FAIL");
      $finish;
   end
endmodule
